// File: design/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int KEY_W           = 32;
    localparam int STATUS_W        = 3;

    localparam logic REQ_INSERT = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4
    } skt_status_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic start;
        logic probe;
        logic compare;
        logic decide;
        logic shift_step;
        logic place;
        logic load_out;
    } skt_cmd_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic search_open;
        logic need_update;
        logic is_insert;
        logic shift_done;
        logic out_free;
    } skt_sts_t;

endpackage

// File: design/sorted_key_table_binary_search_top.sv
// A transaction runs as search probes (read, then compare) for at most ceil(log2(count+1))
// probes, a closing check of the search, a decide step and the load of the output register.
// An insert first moves the entries from the position upward one place up and then places the
// new key; a remove moves the entries above the position one place down.
// One transaction is in work at a time; the next is taken in the cycle after the result is
// loaded, and an output stall holds back that load and so the next transaction.
// Reset clears the count, shift and handshake state only; the key RAM needs no clearing pass.
`timescale 1ns / 1ps

module sorted_key_table_binary_search_top #(
    parameter  int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic [skt_pkg::KEY_W-1:0]    key,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [skt_pkg::STATUS_W-1:0] status,
    output logic [CNT_W-1:0]             position,
    output logic [CNT_W-1:0]             entry_count
);

    import skt_pkg::*;

    skt_cmd_t cmd;
    skt_sts_t sts;

    skt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    skt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .position    (position),
        .entry_count (entry_count)
    );

    // The table never reports more keys than it can hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= CNT_W'(TABLE_DEPTH)))
        else $error("entry count exceeds table depth");

    // The reported position never exceeds the number of keys held.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (position <= entry_count))
        else $error("position beyond entry count");

    // A newly inserted key sits below the new count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_INSERTED)) |-> (position < entry_count))
        else $error("inserted key position out of range");

    // Once a transaction is taken, the input side is held off while it is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transaction accepted during processing");

endmodule

// File: design/skt_ram.sv
`timescale 1ns / 1ps

module skt_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/skt_ctrl.sv
`timescale 1ns / 1ps

module skt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  skt_pkg::skt_sts_t sts,
    output skt_pkg::skt_cmd_t cmd
);

    import skt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_PROBE   = 7'b0000010,
        S_COMPARE = 7'b0000100,
        S_DECIDE  = 7'b0001000,
        S_SHIFT   = 7'b0010000,
        S_PLACE   = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (sts.search_open)
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_COMPARE;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = S_PROBE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.need_update ? S_SHIFT : S_DONE;
            end
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = sts.is_insert ? S_PLACE : S_DONE;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// File: design/skt_dp.sv
`timescale 1ns / 1ps

module skt_dp #(
    parameter  int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  skt_pkg::skt_cmd_t            cmd,
    output skt_pkg::skt_sts_t            sts,
    input  logic                         req_type,
    input  logic [skt_pkg::KEY_W-1:0]    key,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [skt_pkg::STATUS_W-1:0] status,
    output logic [CNT_W-1:0]             position,
    output logic [CNT_W-1:0]             entry_count
);

    import skt_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Control state.
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  shift_n_reg, shift_n_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              out_valid_reg, out_valid_next;

    // Payload.
    logic              req_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [ADDR_W-1:0] mid_reg;
    logic              eq_reg;
    skt_status_t       status_reg;
    logic [ADDR_W-1:0] src_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    skt_status_t       out_status_reg;
    logic [CNT_W-1:0]  out_pos_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic [CNT_W-1:0]  mid_wide;
    logic [CNT_W-1:0]  mid_p1;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  lo_p1;
    logic              is_full;
    logic              is_insert;
    logic              need_update;
    skt_status_t       dec_status;
    logic              shift_rd;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;

    assign mid_wide  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_p1    = CNT_W'(mid_reg) + CNT_W'(1);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign lo_p1     = lo_reg + CNT_W'(1);
    assign is_full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign is_insert = (req_reg == REQ_INSERT);
    assign shift_rd  = cmd.shift_step && (shift_n_reg != '0);

    // A hit is known from the search alone: the last time the upper bound
    // moved, it moved onto the final position, and the flag recorded then
    // tells whether that entry equals the key.
    always_comb
    begin
        dec_status  = ST_ABSENT;
        need_update = 1'b0;
        if (is_insert)
        begin
            if (eq_reg)
            begin
                dec_status = ST_PRESENT;
            end
            else if (is_full)
            begin
                dec_status = ST_FULL;
            end
            else
            begin
                dec_status  = ST_INSERTED;
                need_update = 1'b1;
            end
        end
        else if (eq_reg)
        begin
            dec_status  = ST_REMOVED;
            need_update = 1'b1;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        shift_n_next   = shift_n_reg;
        wr_pend_next   = shift_rd;
        out_valid_next = out_valid_reg;
        if (cmd.decide && need_update)
        begin
            if (is_insert)
            begin
                count_next   = count_reg + CNT_W'(1);
                shift_n_next = count_reg - lo_reg;
            end
            else
            begin
                count_next   = cnt_m1;
                shift_n_next = cnt_m1 - lo_reg;
            end
        end
        else if (shift_rd)
        begin
            shift_n_next = shift_n_reg - CNT_W'(1);
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            shift_n_reg   <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            shift_n_reg   <= shift_n_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg <= req_type;
            key_reg <= key;
            lo_reg  <= '0;
            hi_reg  <= count_reg;
            eq_reg  <= 1'b0;
        end
        if (cmd.probe)
        begin
            mid_reg <= mid_wide[ADDR_W-1:0];
        end
        if (cmd.compare)
        begin
            if (ram_rdata < key_reg)
            begin
                lo_reg <= mid_p1;
            end
            else
            begin
                hi_reg <= CNT_W'(mid_reg);
                eq_reg <= (ram_rdata == key_reg);
            end
        end
        if (cmd.decide)
        begin
            status_reg <= dec_status;
            src_reg    <= is_insert ? cnt_m1[ADDR_W-1:0] : lo_p1[ADDR_W-1:0];
        end
        if (shift_rd)
        begin
            src_reg     <= is_insert ? (src_reg - ADDR_W'(1)) : (src_reg + ADDR_W'(1));
            wr_addr_reg <= is_insert ? (src_reg + ADDR_W'(1)) : (src_reg - ADDR_W'(1));
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_pos_reg    <= lo_reg;
            out_count_reg  <= count_reg;
        end
    end

    // Each shift transfer reads one entry and writes it one place along in
    // the following cycle, so reads and writes overlap at one per cycle.
    assign ram_re    = cmd.probe || shift_rd;
    assign ram_raddr = cmd.probe ? mid_wide[ADDR_W-1:0] : src_reg;
    assign ram_we    = wr_pend_reg || cmd.place;
    assign ram_waddr = wr_pend_reg ? wr_addr_reg : lo_reg[ADDR_W-1:0];
    assign ram_wdata = wr_pend_reg ? ram_rdata : key_reg;

    skt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sts.search_open = (lo_reg < hi_reg);
    assign sts.need_update = need_update;
    assign sts.is_insert   = is_insert;
    assign sts.shift_done  = (shift_n_reg == '0) && !wr_pend_reg;
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign position    = out_pos_reg;
    assign entry_count = out_count_reg;

endmodule
